// ===== hdl/tcfs_pkg.sv =====
// Shared types, widths and codes for the triangle corner placement block.
// Used by tcfs_div, tcfs_sqrt and triangle_corners_from_sides.
package tcfs_pkg;

	localparam int SideW   = 24;
	localparam int SqW     = 2 * SideW;
	localparam int DvdW    = SqW + 2;
	localparam int OutW    = 26;
	localparam int RootW   = SideW;
	localparam int AddrW   = 3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_TIE   = 2'd2;
	localparam logic [1:0] ST_DEGEN = 2'd3;

	// lower corner codes
	localparam logic [1:0] SIDE_NONE  = 2'd0;
	localparam logic [1:0] SIDE_LEFT  = 2'd1;
	localparam logic [1:0] SIDE_RIGHT = 2'd2;

	// register select (paddr bit 2)
	localparam logic REG_MIN_SIDE = 1'b0;
	localparam logic REG_TIE_BAND = 1'b1;

	localparam logic [SideW-1:0] MIN_SIDE_RST = 24'd655;
	localparam logic [SideW-1:0] TIE_BAND_RST = 24'd66;

	// per-item context carried beside the arithmetic units
	typedef struct packed {
		logic [1:0]              status;
		logic                    left;
		logic [SideW-1:0]        a;
		logic [SideW-1:0]        b;
		logic [SideW-1:0]        c;
		logic signed [SideW-1:0] by;
		logic signed [SideW-1:0] pz;
		logic [RootW-1:0]        ha;
	} ctx_t;

endpackage

// ===== hdl/triangle_corners_from_sides.sv =====
// Top level: triangle corner placement from three sides, fully pipelined.
// Depends on tcfs_pkg, tcfs_div and tcfs_sqrt.
//
// Usage:
//   Drive side_a, side_b, side_c, base_y and plane_z with start high for one
//   cycle; the item is taken at that edge. busy is always low, so a new item
//   may be started in every cycle.
//   Each item yields one result on status, lower_side, first_x, second_x,
//   upper_y, third_x, third_y and corner_z, marked by result_valid for one
//   cycle. Results leave in start order.
//   The pipeline has three entry stages, a 24-stage divider,
//   two stages, a 24-stage square root, two stages, a second 24-stage square
//   root and an output stage. Throughput is one item per cycle.
//   The receiver cannot stall; results must be taken when shown.
//   min_side (0x0) and tie_band (0x4) are written over the APB port; write
//   them only while no item is in flight (the block does not enforce this); both read back.
//   Reset (arst_n low) empties the pipeline, drops items in flight and loads
//   min_side = 655 and tie_band = 66.
module triangle_corners_from_sides (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [tcfs_pkg::SideW-1:0]         side_a,
	input  logic [tcfs_pkg::SideW-1:0]         side_b,
	input  logic [tcfs_pkg::SideW-1:0]         side_c,
	input  logic signed [tcfs_pkg::SideW-1:0]  base_y,
	input  logic signed [tcfs_pkg::SideW-1:0]  plane_z,
	output logic                               result_valid,
	output logic [1:0]                         status,
	output logic [1:0]                         lower_side,
	output logic signed [tcfs_pkg::OutW-1:0]   first_x,
	output logic signed [tcfs_pkg::OutW-1:0]   second_x,
	output logic signed [tcfs_pkg::OutW-1:0]   upper_y,
	output logic signed [tcfs_pkg::OutW-1:0]   third_x,
	output logic signed [tcfs_pkg::SideW-1:0]  third_y,
	output logic signed [tcfs_pkg::SideW-1:0]  corner_z,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tcfs_pkg::AddrW-1:0]         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import tcfs_pkg::*;

	logic [SideW-1:0] min_side_q;
	logic [SideW-1:0] tie_band_q;

	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_side_q <= MIN_SIDE_RST;
			tie_band_q <= TIE_BAND_RST;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_MIN_SIDE) begin
				min_side_q <= pwdata[SideW-1:0];
			end else begin
				tie_band_q <= pwdata[SideW-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_TIE_BAND) ? {8'd0, tie_band_q} : {8'd0, min_side_q};

	// entry: checks and squares
	logic signed [SideW+1:0] sb, sc, band, lo_lim, hi_lim;
	logic                    short_side, is_left, is_right;
	ctx_t                    ctx_in;

	assign sb     = {2'b00, side_b};
	assign sc     = {2'b00, side_c};
	assign band   = {2'b00, tie_band_q};
	assign lo_lim = sc - band;
	assign hi_lim = sc + band;
	assign is_left  = sb < lo_lim;
	assign is_right = sb > hi_lim;
	assign short_side = (side_a < min_side_q) || (side_b < min_side_q) ||
		(side_c < min_side_q);

	always_comb begin
		ctx_in        = '0;
		ctx_in.a      = side_a;
		ctx_in.b      = side_b;
		ctx_in.c      = side_c;
		ctx_in.by     = base_y;
		ctx_in.pz     = plane_z;
		ctx_in.left   = is_left;
		if (short_side) begin
			ctx_in.status = ST_SHORT;
		end else if (!is_left && !is_right) begin
			ctx_in.status = ST_TIE;
		end else begin
			ctx_in.status = ST_OK;
		end
	end

	logic             v_s1;
	ctx_t             ctx_s1;
	logic [SqW-1:0]   aa_s1, bb_s1, cc_s1, ab_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s1 <= ctx_in;
		aa_s1  <= side_a * side_a;
		bb_s1  <= side_b * side_b;
		cc_s1  <= side_c * side_c;
		ab_s1  <= side_a * side_b;
	end

	// s2: N = A^2 + B^2 - C^2, keep its magnitude
	logic signed [DvdW-1:0] n_val;
	logic                   v_s2;
	ctx_t                   ctx_s2;
	logic [SqW:0]           mag_s2;
	logic [SqW-1:0]         ab_s2;

	assign n_val = $signed({2'b00, aa_s1}) + $signed({2'b00, bb_s1}) -
		$signed({2'b00, cc_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s2 <= ctx_s1;
		ab_s2  <= ab_s1;
		mag_s2 <= n_val[DvdW-1] ? (SqW+1)'(-n_val) : (SqW+1)'(n_val);
	end

	// s3: degenerate check, dividend for rounded projection
	logic           v_s3;
	ctx_t           ctx_chk;
	ctx_t           ctx_s3;
	logic [DvdW-1:0] dvd_s3;

	always_comb begin
		ctx_chk = ctx_s2;
		if (ctx_s2.status == ST_OK && mag_s2 >= {ab_s2, 1'b0}) begin
			ctx_chk.status = ST_DEGEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s3 <= ctx_chk;
		dvd_s3 <= {1'b0, mag_s2} + {{(DvdW-SideW){1'b0}}, ctx_s2.a};
	end

	logic             v_div;
	logic [RootW-1:0] p_div;
	ctx_t             ctx_div;

	tcfs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.dvd       (dvd_s3),
		.in_ctx    (ctx_s3),
		.out_valid (v_div),
		.quo       (p_div),
		.out_ctx   (ctx_div)
	);

	// s4/s5: B^2 - p^2, clamped
	logic           v_s4, v_s5;
	ctx_t           ctx_s4, ctx_s5;
	logic [SqW-1:0] pp_s4, bb_s4, rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s4 <= v_div;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s4 <= ctx_div;
		pp_s4  <= p_div * p_div;
		bb_s4  <= ctx_div.b * ctx_div.b;
		ctx_s5 <= ctx_s4;
		rad_s5 <= (bb_s4 > pp_s4) ? bb_s4 - pp_s4 : '0;
	end

	logic             v_rt1;
	logic [RootW-1:0] ha_rt1;
	ctx_t             ctx_rt1;

	tcfs_sqrt u_sqrt_h (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.rad       (rad_s5),
		.in_ctx    (ctx_s5),
		.out_valid (v_rt1),
		.root      (ha_rt1),
		.out_ctx   (ctx_rt1)
	);

	// s6/s7: S^2 - ha^2 with S the shorter of b and c, clamped
	logic             v_s6, v_s7;
	ctx_t             ctx_ha;
	ctx_t             ctx_s6, ctx_s7;
	logic [SqW-1:0]   hh_s6, ss_s6, rad_s7;
	logic [SideW-1:0] s_pick;

	assign s_pick = ctx_rt1.left ? ctx_rt1.b : ctx_rt1.c;

	always_comb begin
		ctx_ha    = ctx_rt1;
		ctx_ha.ha = ha_rt1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s6 <= v_rt1;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		ctx_s6    <= ctx_ha;
		hh_s6     <= ha_rt1 * ha_rt1;
		ss_s6     <= s_pick * s_pick;
		ctx_s7    <= ctx_s6;
		rad_s7    <= (ss_s6 > hh_s6) ? ss_s6 - hh_s6 : '0;
	end

	logic             v_rt2;
	logic [RootW-1:0] d_rt2;
	ctx_t             ctx_rt2;

	tcfs_sqrt u_sqrt_d (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s7),
		.rad       (rad_s7),
		.in_ctx    (ctx_s7),
		.out_valid (v_rt2),
		.root      (d_rt2),
		.out_ctx   (ctx_rt2)
	);

	// s8: corner coordinates, zero the side and all coordinates on error
	logic signed [OutW-1:0] half_w, d_w;
	logic                   v_s8;
	logic [1:0]             status_s8, side_s8;
	logic signed [OutW-1:0] x1_s8, x2_s8, uy_s8, x3_s8;
	logic signed [SideW-1:0] y3_s8, z3_s8;

	assign half_w = {3'b000, ctx_rt2.a[SideW-1:1]};
	assign d_w    = {2'b00, d_rt2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else begin
			v_s8 <= v_rt2;
		end
	end

	always_ff @(posedge clk) begin
		status_s8 <= ctx_rt2.status;
		if (ctx_rt2.status != ST_OK) begin
			side_s8 <= SIDE_NONE;
			x1_s8   <= '0;
			x2_s8   <= '0;
			uy_s8   <= '0;
			x3_s8   <= '0;
			y3_s8   <= '0;
			z3_s8   <= '0;
		end else begin
			side_s8 <= ctx_rt2.left ? SIDE_LEFT : SIDE_RIGHT;
			x1_s8   <= -half_w;
			x2_s8   <= half_w;
			uy_s8   <= {{2{ctx_rt2.by[SideW-1]}}, ctx_rt2.by} + {2'b00, ctx_rt2.ha};
			x3_s8   <= ctx_rt2.left ? d_w - half_w : half_w - d_w;
			y3_s8   <= ctx_rt2.by;
			z3_s8   <= ctx_rt2.pz;
		end
	end

	assign result_valid = v_s8;
	assign status       = status_s8;
	assign lower_side   = side_s8;
	assign first_x      = x1_s8;
	assign second_x     = x2_s8;
	assign upper_y      = uy_s8;
	assign third_x      = x3_s8;
	assign third_y      = y3_s8;
	assign corner_z     = z3_s8;

`ifndef SYNTHESIS
	a_latency : assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##80 result_valid)
		else $error("item lost in pipeline");
	a_no_spurious : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start, 80))
		else $error("result without item");
	a_err_zero : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_OK |->
			lower_side == SIDE_NONE && first_x == 0 && third_x == 0 && upper_y == 0)
		else $error("error result not cleared");
	a_ok_side : assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == ST_OK |->
			(lower_side == SIDE_LEFT || lower_side == SIDE_RIGHT) &&
			second_x == -first_x)
		else $error("ok result malformed");
`endif

endmodule

// ===== hdl/tcfs_div.sv =====
// Pipelined restoring divider, one quotient bit per stage: (dvd) / (2*ctx.a).
// Depends on tcfs_pkg; quotient is valid when it fits in RootW bits.
module tcfs_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [tcfs_pkg::DvdW-1:0] dvd,
	input  tcfs_pkg::ctx_t           in_ctx,
	output logic                     out_valid,
	output logic [tcfs_pkg::RootW-1:0] quo,
	output tcfs_pkg::ctx_t           out_ctx
);
	import tcfs_pkg::*;

	localparam int N = RootW;
	localparam int RemW = SideW + 2;

	logic             v_s   [N];
	logic [RemW-1:0]  rem_s [N];
	logic [N-1:0]     lo_s  [N];
	logic [N-1:0]     quo_s [N];
	ctx_t             ctx_s [N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic            vi;
			logic [RemW-1:0] ri;
			logic [N-1:0]    li;
			logic [N-1:0]    qi;
			ctx_t            ci;
			logic [RemW-1:0] trial;
			logic [RemW-1:0] dvs;
			if (k == 0) begin : g_first
				assign vi = in_valid;
				assign ri = dvd[DvdW-1:N];
				assign li = dvd[N-1:0];
				assign qi = '0;
				assign ci = in_ctx;
			end else begin : g_next
				assign vi = v_s[k-1];
				assign ri = rem_s[k-1];
				assign li = lo_s[k-1];
				assign qi = quo_s[k-1];
				assign ci = ctx_s[k-1];
			end
			assign trial = {ri[RemW-2:0], li[N-1]};
			assign dvs   = {1'b0, ci.a, 1'b0};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else begin
					v_s[k] <= vi;
				end
			end

			always_ff @(posedge clk) begin
				if (trial >= dvs) begin
					rem_s[k] <= trial - dvs;
					quo_s[k] <= {qi[N-2:0], 1'b1};
				end else begin
					rem_s[k] <= trial;
					quo_s[k] <= {qi[N-2:0], 1'b0};
				end
				lo_s[k]  <= {li[N-2:0], 1'b0};
				ctx_s[k] <= ci;
			end
		end
	endgenerate

	assign out_valid = v_s[N-1];
	assign quo       = quo_s[N-1];
	assign out_ctx   = ctx_s[N-1];

endmodule

// ===== hdl/tcfs_sqrt.sv =====
// Pipelined integer square root (floor), one root bit per stage.
// Depends on tcfs_pkg; carries the item context alongside.
module tcfs_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [tcfs_pkg::SqW-1:0]   rad,
	input  tcfs_pkg::ctx_t             in_ctx,
	output logic                       out_valid,
	output logic [tcfs_pkg::RootW-1:0] root,
	output tcfs_pkg::ctx_t             out_ctx
);
	import tcfs_pkg::*;

	localparam int N = RootW;
	localparam int RemW = RootW + 2;

	logic             v_s    [N];
	logic [RemW-1:0]  rem_s  [N];
	logic [SqW-1:0]   rad_s  [N];
	logic [N-1:0]     root_s [N];
	ctx_t             ctx_s  [N];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic            vi;
			logic [RemW-1:0] ri;
			logic [SqW-1:0]  di;
			logic [N-1:0]    qi;
			ctx_t            ci;
			logic [RemW+1:0] t;
			logic [RemW+1:0] trial;
			if (k == 0) begin : g_first
				assign vi = in_valid;
				assign ri = '0;
				assign di = rad;
				assign qi = '0;
				assign ci = in_ctx;
			end else begin : g_next
				assign vi = v_s[k-1];
				assign ri = rem_s[k-1];
				assign di = rad_s[k-1];
				assign qi = root_s[k-1];
				assign ci = ctx_s[k-1];
			end
			assign t     = {ri, di[SqW-1:SqW-2]};
			assign trial = {2'b00, qi, 2'b01};

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_s[k] <= 1'b0;
				end else begin
					v_s[k] <= vi;
				end
			end

			always_ff @(posedge clk) begin
				if (t >= trial) begin
					rem_s[k]  <= RemW'(t - trial);
					root_s[k] <= {qi[N-2:0], 1'b1};
				end else begin
					rem_s[k]  <= RemW'(t);
					root_s[k] <= {qi[N-2:0], 1'b0};
				end
				rad_s[k] <= {di[SqW-3:0], 2'b00};
				ctx_s[k] <= ci;
			end
		end
	endgenerate

	assign out_valid = v_s[N-1];
	assign root      = root_s[N-1];
	assign out_ctx   = ctx_s[N-1];

endmodule
